### rtl/core/rmsng_pkg.sv
// Shared constants, codes and types of the RMS noise gate.
package rmsng_pkg;

   // Sample format and window sizing
   localparam int SAMPLE_BITS = 24;
   localparam int MAX_WINDOW  = 1024;
   localparam int CNT_W       = $clog2(MAX_WINDOW);
   localparam int LEN_W       = 11;
   localparam int SQ_W        = 2 * SAMPLE_BITS;
   localparam int SUM_W       = 56;
   localparam int STEP_W      = 16;

   // Gain is unsigned Q1.24, the ramp increment a signed Q1.24 value
   localparam int GAIN_FRAC   = 24;
   localparam int GAIN_W      = GAIN_FRAC + 1;
   localparam int INC_W       = GAIN_W + 1;
   localparam int DIV_CNT_W   = $clog2(GAIN_W);
   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

   // Queue between the front and the back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Configuration register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SUM_W;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SUMSQ_THRESH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_STEPS  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_STEPS = 2'd3;

   // Configuration reset values
   localparam logic [LEN_W-1:0]  WINDOW_LEN_RST    = 11'd48;
   localparam logic [SUM_W-1:0]  SUMSQ_THRESH_RST  = 56'd337769972;
   localparam logic [STEP_W-1:0] ATTACK_STEPS_RST  = 16'd480;
   localparam logic [STEP_W-1:0] RELEASE_STEPS_RST = 16'd4800;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          win_end;
      logic                          open_gate;
   } queue_item_type;

   typedef struct packed {
      logic [LEN_W-1:0] window_len;
      logic [SUM_W-1:0] threshold;
   } front_cfg_type;

   typedef struct packed {
      logic [STEP_W-1:0] attack_steps;
      logic [STEP_W-1:0] release_steps;
   } back_cfg_type;

endpackage

### rtl/core/rms_noise_gate.sv
// Top level of the block-RMS noise gate with linear gain ramp.
// Block-RMS noise gate. Every sample transferred in on push/full yields exactly one
// result on empty/pop: the sample times the current gain (Q1.24), floored to Q1.23,
// plus the latest gate decision. A front section squares each sample and adds it to
// a saturating 56-bit window sum; after window_len samples the sum is compared
// (strictly greater) with sumsq_threshold to open or close the gate. A four-entry
// queue hands the samples to a back section, which at a window end divides the
// distance to the new gain target by attack_steps or release_steps (one quotient bit
// per cycle), then steps the gain, multiplies and loads the result register. An
// ordinary sample passes the ramp, multiply and output states; a sample that ends a
// window first runs the 25-step serial divider and a sign state. The back takes the
// next sample only after loading the result register. Write the configuration
// registers only while the block is idle; all reset to their defaults.
module rms_noise_gate (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      push,
   output logic                                      full,
   input  logic signed [rmsng_pkg::SAMPLE_BITS-1:0]  req_sample_in,
   output logic                                      empty,
   input  logic                                      pop,
   output logic signed [rmsng_pkg::SAMPLE_BITS-1:0]  rsp_sample_out,
   output logic                                      rsp_gate_open,
   input  logic                                      csr_we,
   input  logic [rmsng_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [rmsng_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   rmsng_pkg::front_cfg_type  front_cfg_ff;
   rmsng_pkg::back_cfg_type   back_cfg_ff;
   rmsng_pkg::queue_item_type q_push_item, q_pop_item;
   logic                      q_push, q_full, q_pop, q_empty;

   // Configuration registers: take the low bits of the write data
   always_ff @(posedge clock) begin
      if (reset) begin
         front_cfg_ff.window_len    <= rmsng_pkg::WINDOW_LEN_RST;
         front_cfg_ff.threshold     <= rmsng_pkg::SUMSQ_THRESH_RST;
         back_cfg_ff.attack_steps   <= rmsng_pkg::ATTACK_STEPS_RST;
         back_cfg_ff.release_steps  <= rmsng_pkg::RELEASE_STEPS_RST;
      end else if (csr_we) begin
         case (csr_index)
            rmsng_pkg::CSR_WINDOW_LEN:
               front_cfg_ff.window_len <= csr_wdata[rmsng_pkg::LEN_W-1:0];
            rmsng_pkg::CSR_SUMSQ_THRESH:
               front_cfg_ff.threshold <= csr_wdata[rmsng_pkg::SUM_W-1:0];
            rmsng_pkg::CSR_ATTACK_STEPS:
               back_cfg_ff.attack_steps <= csr_wdata[rmsng_pkg::STEP_W-1:0];
            rmsng_pkg::CSR_RELEASE_STEPS:
               back_cfg_ff.release_steps <= csr_wdata[rmsng_pkg::STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Front: classify each sample as window end or not, with its decision
   rmsng_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (front_cfg_ff),
      .push      (push),
      .full      (full),
      .sample_in (req_sample_in),
      .q_push    (q_push),
      .q_full    (q_full),
      .q_item    (q_push_item)
   );

   // Decouple the front from the multi-cycle back
   rmsng_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .full      (q_full),
      .push_item (q_push_item),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_item  (q_pop_item)
   );

   // Back: ramp, multiply and hold the result until it is transferred out
   rmsng_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (back_cfg_ff),
      .q_pop         (q_pop),
      .q_empty       (q_empty),
      .q_item        (q_pop_item),
      .rsp_empty     (empty),
      .rsp_pop       (pop),
      .rsp_sample    (rsp_sample_out),
      .rsp_gate_open (rsp_gate_open)
   );

   // The front never pushes into a full queue
   assert property (@(posedge clock) disable iff (reset) !(q_push && q_full))
      else $error("front pushed into a full queue");

   // The back never pops an empty queue
   assert property (@(posedge clock) disable iff (reset) !(q_pop && q_empty))
      else $error("back popped an empty queue");

   // Reset leaves no result pending
   assert property (@(posedge clock) reset |=> empty)
      else $error("result pending after reset");

endmodule

### rtl/core/rmsng_queue.sv
// Short flip-flop queue of classified samples between front and back.
module rmsng_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  rmsng_pkg::queue_item_type push_item,
   input  logic                      pop,
   output logic                      empty,
   output rmsng_pkg::queue_item_type pop_item
);

   rmsng_pkg::queue_item_type           slot_ff [rmsng_pkg::QUEUE_DEPTH];
   logic [rmsng_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [rmsng_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [rmsng_pkg::QPTR_W:0]          count_ff, count_in;
   logic                                do_push, do_pop;

   assign full     = (count_ff == (rmsng_pkg::QPTR_W+1)'(rmsng_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/core/rmsng_front.sv
// Front: square, window accumulate and gate decision per accepted sample.
module rmsng_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rmsng_pkg::front_cfg_type             cfg,
   input  logic                                 push,
   output logic                                 full,
   input  logic signed [rmsng_pkg::SAMPLE_BITS-1:0] sample_in,
   output logic                                 q_push,
   input  logic                                 q_full,
   output rmsng_pkg::queue_item_type            q_item
);

   logic                                    advance;
   logic                                    a_valid_ff, b_valid_ff;
   logic signed [rmsng_pkg::SAMPLE_BITS-1:0] a_sample_ff, b_sample_ff;
   logic signed [rmsng_pkg::SQ_W-1:0]       sq_signed;
   logic [rmsng_pkg::SQ_W-1:0]              sq_ff;
   logic [rmsng_pkg::SUM_W-1:0]             sum_ff, sum_in, sum_sat;
   logic [rmsng_pkg::SUM_W:0]               sum_add;
   logic [rmsng_pkg::CNT_W-1:0]             cnt_ff, cnt_in;
   logic [rmsng_pkg::LEN_W-1:0]             cnt_next, len_eff;
   logic                                    win_end, open_gate;

   // Stall the whole front while the decided sample cannot enter the queue
   assign advance   = !(b_valid_ff && q_full);
   assign full      = !advance;
   assign sq_signed = a_sample_ff * a_sample_ff;

   always_comb begin
      if (cfg.window_len == '0) begin
         len_eff = rmsng_pkg::LEN_W'(1);
      end else if (cfg.window_len > rmsng_pkg::LEN_W'(rmsng_pkg::MAX_WINDOW)) begin
         len_eff = rmsng_pkg::LEN_W'(rmsng_pkg::MAX_WINDOW);
      end else begin
         len_eff = cfg.window_len;
      end
      sum_add   = {1'b0, sum_ff} + (rmsng_pkg::SUM_W+1)'(sq_ff);
      sum_sat   = sum_add[rmsng_pkg::SUM_W] ? '1 : sum_add[rmsng_pkg::SUM_W-1:0];
      cnt_next  = rmsng_pkg::LEN_W'(cnt_ff) + rmsng_pkg::LEN_W'(1);
      win_end   = (cnt_next >= len_eff);
      open_gate = (sum_sat > cfg.threshold);
      sum_in    = win_end ? '0 : sum_sat;
      cnt_in    = win_end ? '0 : cnt_next[rmsng_pkg::CNT_W-1:0];
   end

   assign q_push           = b_valid_ff && advance;
   assign q_item.sample    = b_sample_ff;
   assign q_item.win_end   = win_end;
   assign q_item.open_gate = open_gate;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         sum_ff     <= '0;
         cnt_ff     <= '0;
      end else if (advance) begin
         a_valid_ff <= push;
         b_valid_ff <= a_valid_ff;
         if (b_valid_ff) begin
            sum_ff <= sum_in;
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_sample_ff <= sample_in;
         b_sample_ff <= a_sample_ff;
         sq_ff       <= $unsigned(sq_signed);
      end
   end

endmodule

### rtl/core/rmsng_back.sv
// Back: ramp increment division, gain ramp, gain multiply and result register.
module rmsng_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rmsng_pkg::back_cfg_type               cfg,
   output logic                                  q_pop,
   input  logic                                  q_empty,
   input  rmsng_pkg::queue_item_type             q_item,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [rmsng_pkg::SAMPLE_BITS-1:0] rsp_sample,
   output logic                                  rsp_gate_open
);

   localparam int PROD_W = rmsng_pkg::SAMPLE_BITS + rmsng_pkg::GAIN_W + 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_SIGN = 3'd2;
   localparam logic [2:0] ST_RAMP = 3'd3;
   localparam logic [2:0] ST_MUL  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]                               state_ff, state_in;
   logic signed [rmsng_pkg::SAMPLE_BITS-1:0] sample_ff;
   logic                                     open_ff, open_in;
   logic [rmsng_pkg::GAIN_W-1:0]             gain_ff, gain_in;
   logic signed [rmsng_pkg::INC_W-1:0]       inc_ff, inc_in;
   logic                                     neg_ff, mag_nz_ff;
   logic [rmsng_pkg::GAIN_W-1:0]             dq_ff, dq_in;
   logic [rmsng_pkg::STEP_W-1:0]             rem_ff, rem_in;
   logic [rmsng_pkg::STEP_W-1:0]             divisor_ff, steps_eff;
   logic [rmsng_pkg::DIV_CNT_W-1:0]          bit_cnt_ff;
   logic signed [PROD_W-1:0]                 prod_ff;
   logic                                     rsp_valid_ff;
   logic signed [rmsng_pkg::SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                                     rsp_open_ff;

   logic [rmsng_pkg::GAIN_W-1:0]             new_target, cur_target;
   logic signed [rmsng_pkg::INC_W-1:0]       new_diff, cur_diff, gain_sum;
   logic [rmsng_pkg::INC_W-1:0]              new_abs, cur_abs, inc_abs;
   logic [rmsng_pkg::STEP_W:0]               shifted, trial;
   logic                                     fits;
   logic [rmsng_pkg::GAIN_W-1:0]             inc_mag;
   logic                                     rsp_load;

   assign q_pop         = (state_ff == ST_IDLE) && !q_empty;
   assign rsp_load      = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_pop);
   assign rsp_empty     = !rsp_valid_ff;
   assign rsp_sample    = rsp_sample_ff;
   assign rsp_gate_open = rsp_open_ff;

   always_comb begin
      // Decision taken from the queue head
      new_target = q_item.open_gate ? rmsng_pkg::GAIN_ONE : '0;
      new_diff   = $signed({1'b0, new_target}) - $signed({1'b0, gain_ff});
      new_abs    = new_diff[rmsng_pkg::INC_W-1] ? -new_diff : new_diff;
      steps_eff  = q_item.open_gate ? cfg.attack_steps : cfg.release_steps;
      if (steps_eff == '0) begin
         steps_eff = rmsng_pkg::STEP_W'(1);
      end

      // One restoring division step per cycle
      shifted = {rem_ff, dq_ff[rmsng_pkg::GAIN_W-1]};
      trial   = shifted - {1'b0, divisor_ff};
      fits    = (shifted >= {1'b0, divisor_ff});
      rem_in  = fits ? trial[rmsng_pkg::STEP_W-1:0] : shifted[rmsng_pkg::STEP_W-1:0];
      dq_in   = {dq_ff[rmsng_pkg::GAIN_W-2:0], fits};

      // Truncated quotient, forced to one unit when it would stall the ramp
      inc_mag = (dq_ff == '0 && mag_nz_ff) ? rmsng_pkg::GAIN_W'(1) : dq_ff;
      inc_in  = neg_ff ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});

      // Ramp step with snap to target
      cur_target = open_ff ? rmsng_pkg::GAIN_ONE : '0;
      cur_diff   = $signed({1'b0, cur_target}) - $signed({1'b0, gain_ff});
      cur_abs    = cur_diff[rmsng_pkg::INC_W-1] ? -cur_diff : cur_diff;
      inc_abs    = inc_ff[rmsng_pkg::INC_W-1] ? -inc_ff : inc_ff;
      gain_sum   = $signed({1'b0, gain_ff}) + inc_ff;
      gain_in    = (cur_abs < inc_abs) ? cur_target : gain_sum[rmsng_pkg::GAIN_W-1:0];

      open_in  = open_ff;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               if (q_item.win_end) begin
                  open_in  = q_item.open_gate;
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_RAMP;
               end
            end
         end
         ST_DIV: begin
            if (bit_cnt_ff == rmsng_pkg::DIV_CNT_W'(rmsng_pkg::GAIN_W - 1)) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: state_in = ST_RAMP;
         ST_RAMP: state_in = ST_MUL;
         ST_MUL:  state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         open_ff      <= 1'b0;
         gain_ff      <= '0;
         inc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         open_ff  <= open_in;
         if (state_ff == ST_SIGN) begin
            inc_ff <= inc_in;
         end
         if (state_ff == ST_RAMP) begin
            gain_ff <= gain_in;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         sample_ff  <= q_item.sample;
         neg_ff     <= new_diff[rmsng_pkg::INC_W-1];
         mag_nz_ff  <= (new_abs != '0);
         dq_ff      <= new_abs[rmsng_pkg::GAIN_W-1:0];
         rem_ff     <= '0;
         divisor_ff <= steps_eff;
         bit_cnt_ff <= '0;
      end else if (state_ff == ST_DIV) begin
         dq_ff      <= dq_in;
         rem_ff     <= rem_in;
         bit_cnt_ff <= bit_cnt_ff + 1'b1;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= sample_ff * $signed({1'b0, gain_ff});
      end
      if (rsp_load) begin
         rsp_sample_ff <= prod_ff[rmsng_pkg::GAIN_FRAC+rmsng_pkg::SAMPLE_BITS-1:
                                  rmsng_pkg::GAIN_FRAC];
         rsp_open_ff   <= open_ff;
      end
   end

endmodule

### tb/tb.sv
// Self-checking testbench for the block-RMS noise gate with its linear gain ramp.
`timescale 1ns / 1ps

module tb;
   import rmsng_pkg::*;

   localparam int TOTAL_ITEMS   = 1950;
   localparam int SETTLE_CYCLES = 40;    // covers the time a window end keeps the back busy
   localparam int STALL_LIMIT   = 1000;  // cycles without any transfer before giving up

   localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = 24'sh800000;
   localparam longint unsigned SUM_MAX    = (64'd1 << SUM_W) - 64'd1;
   localparam longint          GAIN_UNITY = longint'(GAIN_ONE);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          gate_open;
   } gate_result_type;

   // Clock, reset and every block input start at a known value
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          push = 1'b0;
   logic signed [SAMPLE_BITS-1:0] req_sample_in = '0;
   logic                          pop = 1'b0;
   logic                          csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]          csr_index = '0;
   logic [CSR_DATA_W-1:0]         csr_wdata = '0;
   logic                          full;
   logic                          empty;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out;
   logic                          rsp_gate_open;

   // Samples waiting to be sent, and gated samples waiting to come back
   logic signed [SAMPLE_BITS-1:0] sample_q[$];
   gate_result_type               gated_q[$];

   // Transfers seen at the last rising edge; the drivers read them at the falling edge
   logic req_took = 1'b0;
   logic rsp_took = 1'b0;

   int items_sent  = 0;
   int mismatches  = 0;
   int idle_cycles = 0;
   int send_gap    = 0;
   int send_calm   = 0;
   int take_gap    = 0;
   int take_calm   = 0;

   // Gate shadow: configuration as last written, state as after reset
   logic [LEN_W-1:0]  cfg_win_len = WINDOW_LEN_RST;
   logic [SUM_W-1:0]  cfg_thresh  = SUMSQ_THRESH_RST;
   logic [STEP_W-1:0] cfg_attack  = ATTACK_STEPS_RST;
   logic [STEP_W-1:0] cfg_release = RELEASE_STEPS_RST;
   longint unsigned   sum_sq      = 0;
   int unsigned       win_count   = 0;
   longint            gain        = 0;
   logic              gate_is_open = 1'b0;
   longint            ramp_inc    = 0;

   rms_noise_gate DUT (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_sample_in  (req_sample_in),
      .empty          (empty),
      .pop            (pop),
      .rsp_sample_out (rsp_sample_out),
      .rsp_gate_open  (rsp_gate_open),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Advance the gate shadow by one sample and return the gated sample it produces.
   function automatic gate_result_type predict_gate(input logic signed [SAMPLE_BITS-1:0] smp);
      gate_result_type res;
      longint          s;
      longint          target;
      longint          diff;
      longint          mag;
      longint          steps;
      longint          prod;
      longint unsigned len;
      s = longint'(smp);
      // Accumulate the square, saturating at the top of the 56-bit sum
      sum_sq = sum_sq + longint'(s * s);
      if (sum_sq > SUM_MAX)
         sum_sq = SUM_MAX;
      win_count++;
      // Clamp the window: zero acts as one, anything past the maximum as the maximum
      len = 64'(cfg_win_len);
      if (len == 0)
         len = 1;
      else if (len > MAX_WINDOW)
         len = 64'(MAX_WINDOW);
      // Window end: decide the gate and set a fresh ramp increment toward the target
      if (win_count >= len) begin
         gate_is_open = sum_sq > cfg_thresh;
         target = gate_is_open ? GAIN_UNITY : 0;
         steps = gate_is_open ? longint'(cfg_attack) : longint'(cfg_release);
         if (steps == 0)
            steps = 1;
         diff = target - gain;
         ramp_inc = diff / steps;
         // Never let the increment truncate to nothing while the ramp still has ground to cover
         if (ramp_inc == 0 && diff != 0)
            ramp_inc = (diff > 0) ? 1 : -1;
         sum_sq = 0;
         win_count = 0;
      end
      // Step the gain first, snapping onto the target instead of overshooting it
      target = gate_is_open ? GAIN_UNITY : 0;
      diff = target - gain;
      mag = (diff < 0) ? -diff : diff;
      if (mag < ((ramp_inc < 0) ? -ramp_inc : ramp_inc))
         gain = target;
      else
         gain = gain + ramp_inc;
      // Floor the Q1.23 x Q1.24 product back to Q1.23
      prod = s * gain;
      res.sample_out = SAMPLE_BITS'(prod >>> GAIN_FRAC);
      res.gate_open = gate_is_open;
      return res;
   endfunction

   // Draw a random gap before each transfer, with occasional stretches of back-to-back traffic.
   function automatic int draw_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) begin
         calm_left = $urandom_range(10, 60);
         return 0;
      end
      return $urandom_range(0, 4);
   endfunction

   function automatic logic [STEP_W-1:0] draw_steps();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return STEP_W'($urandom);
         4, 5:    return STEP_W'($urandom_range(9, 300));
         default: return STEP_W'($urandom_range(1, 8));
      endcase
   endfunction

   // Write one register while the gate is idle and mirror it into the shadow.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_WINDOW_LEN:    cfg_win_len = value[LEN_W-1:0];
         CSR_SUMSQ_THRESH:  cfg_thresh  = value[SUM_W-1:0];
         CSR_ATTACK_STEPS:  cfg_attack  = value[STEP_W-1:0];
         CSR_RELEASE_STEPS: cfg_release = value[STEP_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      // Return on a rising edge so the sample queue is never touched beside the driver
      @(posedge clock);
   endtask

   task automatic queue_sample(input logic signed [SAMPLE_BITS-1:0] smp);
      sample_q.push_back(smp);
      items_sent++;
   endtask

   // Hold until every queued sample is sent and every gated sample is back, then let the
   // back section settle. Poll on rising edges, where the queues and push are stable.
   task automatic drain();
      while (sample_q.size() != 0 || push || gated_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sender: present the next sample at the falling edge; hold it until a transfer,
   // then draw a gap before the next one.
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (!push || req_took) begin
         if (push)
            send_gap = draw_wait(send_calm);
         if (send_gap > 0) begin
            send_gap--;
            push <= 1'b0;
         end else if (sample_q.size() != 0) begin
            push          <= 1'b1;
            req_sample_in <= sample_q.pop_front();
         end else begin
            push <= 1'b0;
         end
      end
   end

   // Receiver: raise pop, and after each transfer drop it for a drawn number of cycles.
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (!pop || rsp_took) begin
         if (pop)
            take_gap = draw_wait(take_calm);
         if (take_gap > 0) begin
            take_gap--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Monitor: at each rising edge predict every sample transfer and check every result
   // transfer against the oldest prediction.
   always @(posedge clock) begin
      gate_result_type want;
      req_took <= !reset && push && !full;
      rsp_took <= !reset && pop && !empty;
      if (!reset && push && !full)
         gated_q.push_back(predict_gate(req_sample_in));
      if (!reset && pop && !empty) begin
         if (gated_q.size() == 0) begin
            $display("%0t ns: unexpected result, sample_out %0d gate_open %0b",
                     $time, rsp_sample_out, rsp_gate_open);
            mismatches++;
         end else begin
            want = gated_q.pop_front();
            if (rsp_sample_out !== want.sample_out) begin
               $display("%0t ns: sample_out expected %0d, got %0d",
                        $time, want.sample_out, rsp_sample_out);
               mismatches++;
            end
            if (rsp_gate_open !== want.gate_open) begin
               $display("%0t ns: gate_open expected %0b, got %0b",
                        $time, want.gate_open, rsp_gate_open);
               mismatches++;
            end
         end
      end
      if ((push && !full) || (pop && !empty) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // Watchdog: give up when nothing has moved for too long
   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("tb: errors");
      $finish;
   end

   initial begin
      int                            n;
      int                            loud_pct;
      longint unsigned               eff_len;
      longint unsigned               thr;
      logic signed [SAMPLE_BITS-1:0] smp;

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Steps of zero act as one: the gate swings fully open, then fully shut
      write_reg(CSR_WINDOW_LEN, 2);
      write_reg(CSR_SUMSQ_THRESH, 0);
      write_reg(CSR_ATTACK_STEPS, 0);
      write_reg(CSR_RELEASE_STEPS, 0);
      queue_sample(SMP_MAX);
      queue_sample(SMP_MIN);
      queue_sample(SMP_MAX);
      queue_sample(SMP_MIN);
      queue_sample(0);
      queue_sample(0);
      drain();

      // Longest attack from silence leaves the gain a hair above zero
      write_reg(CSR_WINDOW_LEN, 1);
      write_reg(CSR_ATTACK_STEPS, '1);
      queue_sample(SMP_MAX);
      drain();

      // Closing over the longest release truncates the increment to zero; it must become -1.
      // The top threshold keeps the gate shut.
      write_reg(CSR_SUMSQ_THRESH, CSR_DATA_W'(SUM_MAX));
      write_reg(CSR_RELEASE_STEPS, '1);
      queue_sample(SMP_MIN);
      queue_sample(SMP_MAX);
      queue_sample(1);
      drain();

      // A zero window acts as one: every sample decides, halving the distance to unity
      write_reg(CSR_WINDOW_LEN, 0);
      write_reg(CSR_SUMSQ_THRESH, 0);
      write_reg(CSR_ATTACK_STEPS, 2);
      for (int i = 0; i < 5; i++)
         queue_sample((i % 2 == 0) ? 24'sd1 : -24'sd1);
      drain();

      // An oversized window clamps to the maximum; lowering it under the count ends it next
      write_reg(CSR_WINDOW_LEN, 2047);
      queue_sample(SMP_MAX);
      queue_sample(-1);
      queue_sample(12345);
      drain();
      write_reg(CSR_WINDOW_LEN, 2);
      queue_sample(-2);
      drain();

      // Overflow: open at unity, then a full window of the most negative sample lands the sum
      // exactly on 2^56, which must saturate and so stay at the top threshold and close.
      write_reg(CSR_WINDOW_LEN, 1);
      write_reg(CSR_ATTACK_STEPS, 1);
      queue_sample(SMP_MAX);
      drain();
      write_reg(CSR_WINDOW_LEN, CSR_DATA_W'(MAX_WINDOW));
      write_reg(CSR_SUMSQ_THRESH, CSR_DATA_W'(SUM_MAX));
      write_reg(CSR_RELEASE_STEPS, 1);
      repeat (MAX_WINDOW) queue_sample(SMP_MIN);
      drain();

      // Random phases: rewrite some registers while idle (the window count carries over),
      // then send a burst with a random mix of loud and quiet samples.
      while (items_sent < TOTAL_ITEMS) begin
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
               0:       n = 0;
               1:       n = $urandom_range(0, 2047);
               2:       n = MAX_WINDOW;
               3:       n = 2047;
               4, 5:    n = $urandom_range(9, 64);
               default: n = $urandom_range(1, 8);
            endcase
            write_reg(CSR_WINDOW_LEN, CSR_DATA_W'(n));
         end
         if ($urandom_range(0, 1)) begin
            // Aim most thresholds at the sums this window can reach
            eff_len = (cfg_win_len == 0) ? 64'd1 : (cfg_win_len > MAX_WINDOW) ? 64'(MAX_WINDOW)
                                                                          : 64'(cfg_win_len);
            case ($urandom_range(0, 7))
               0:       thr = 0;
               1:       thr = SUM_MAX;
               2:       thr = {$urandom, $urandom};
               default: thr = eff_len * (64'd1 << $urandom_range(8, 45));
            endcase
            write_reg(CSR_SUMSQ_THRESH, CSR_DATA_W'(thr));
         end
         if ($urandom_range(0, 1))
            write_reg(CSR_ATTACK_STEPS, CSR_DATA_W'(draw_steps()));
         if ($urandom_range(0, 1))
            write_reg(CSR_RELEASE_STEPS, CSR_DATA_W'(draw_steps()));

         n = $urandom_range(20, 150);
         loud_pct = $urandom_range(0, 100);
         repeat (n) begin
            if ($urandom_range(0, 99) < loud_pct) begin
               smp = SAMPLE_BITS'($urandom);
            end else begin
               case ($urandom_range(0, 4))
                  0:       smp = SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
                  1:       smp = $signed(SAMPLE_BITS'($urandom)) >>> $urandom_range(4, 22);
                  2:       smp = SMP_MAX;
                  3:       smp = SMP_MIN;
                  default: smp = SAMPLE_BITS'(int'($urandom_range(0, 2)) - 1);
               endcase
            end
            queue_sample(smp);
         end
         // Pause the sender until every gated sample has come back
         drain();
      end

      drain();
      if (mismatches == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

### files.f
rtl/core/rmsng_pkg.sv
rtl/core/rmsng_queue.sv
rtl/core/rmsng_front.sv
rtl/core/rmsng_back.sv
rtl/core/rms_noise_gate.sv
tb/tb.sv
